[hw/rtl/rsig_pkg.sv]
// Package for the relay signal table: sizes, codes, entry and transaction types.
// Used by rsig_table and relay_signal_table; no dependencies.
`default_nettype none

package rsig_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STR_W    = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned WINDOW_W = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(MS_PER_MINUTE * 15);
  localparam logic [ADDR_W-1:0] EMPTY_RESET = '0;
  localparam logic signed [STR_W-1:0] STRENGTH_RESET = -16'sd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_EMPTY  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_UPDATE    = 1'b0,
    FUNC_RECOMMEND = 1'b1
  } func_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        address;
    logic signed [STR_W-1:0]  strength;
    logic [TIME_W-1:0]        stamp;
  } rsig_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    rsig_entry_t       entry;
  } rsig_wr_t;

  typedef struct packed {
    logic                     func;
    logic [ADDR_W-1:0]        relay_address;
    logic signed [STR_W-1:0]  signal_strength;
    logic [TIME_W-1:0]        now_ms;
  } rsig_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] best_address;
    logic              best_found;
    logic              update_dropped;
  } rsig_out_t;

endpackage

`default_nettype wire

[hw/rtl/rsig_table.sv]
// Relay entry store: one synchronous memory with registered read and per-entry valid bits.
// Depends on rsig_pkg. An entry never written reads as the reset entry.
`default_nettype none

module rsig_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [rsig_pkg::IDX_W-1:0] rd_idx_i,
  output rsig_pkg::rsig_entry_t     rd_entry_o,
  input  wire rsig_pkg::rsig_wr_t   wr_i
);
  import rsig_pkg::*;

  rsig_entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  rsig_entry_t rd_data_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.entry;
    end
    rd_data_q <= mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_idx_i];
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      rd_entry_o = rd_data_q;
    end else begin
      rd_entry_o.address  = EMPTY_RESET;
      rd_entry_o.strength = STRENGTH_RESET;
      rd_entry_o.stamp    = '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_wr_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> vld_q[$past(wr_i.idx)])
    else $error("written entry not marked valid");

  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) >= $past($countones(vld_q)))
    else $error("entry valid bit dropped");

  a_rd_valid_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q == $past(vld_q[rd_idx_i]))
    else $error("read valid does not follow the addressed entry");
`endif

endmodule

`default_nettype wire

[hw/rtl/relay_signal_table.sv]
// Relay signal table top level: transaction sequencer over the entry store.
// Depends on rsig_pkg and rsig_table.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------
//   in       | in_valid_i / in_ready_o    | in_data_i  (rsig_in_t)
//   out      | out_valid_o / out_ready_i  | out_data_o (rsig_out_t)
//   cfg      | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// From accept to result: one store read per entry, then the registered read of the last entry,
// then the end of the walk, then the write-back and the load of the output register; the state
// then returns to idle, and only there is the next transaction accepted.
// Reset clears all entries to the empty address, strength -200, time zero, at once.
// The next transaction is accepted while a result waits in the output register;
// a finished transaction holds until the output register is free.
`default_nettype none

module relay_signal_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire rsig_pkg::rsig_in_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output rsig_pkg::rsig_out_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rsig_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rsig_pkg::CFG_W-1:0]      cfg_data_i
);
  import rsig_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [WINDOW_W-1:0] window_q;
  logic [ADDR_W-1:0]   empty_q;

  rsig_in_t            req_q;
  logic [CNT_W-1:0]    rd_cnt_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                hit_found_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic                best_found_q;
  logic [ADDR_W-1:0]   best_addr_q;
  logic signed [STR_W-1:0] best_str_q;
  logic                out_valid_q;
  rsig_out_t           out_q, out_d;

  rsig_entry_t         rd_entry;
  rsig_wr_t            wr;
  logic [IDX_W-1:0]    rd_idx;
  logic                in_fire;
  logic                out_free;
  logic                issue;
  logic                hit;
  logic                elig;
  logic [TIME_W:0]     limit;

  rsig_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_i       (wr)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign issue  = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(TABLE_ENTRIES));
  assign rd_idx = rd_cnt_q[IDX_W-1:0];

  assign hit   = (rd_entry.address == req_q.relay_address) || (rd_entry.address == empty_q);
  assign limit = {1'b0, rd_entry.stamp} + (TIME_W + 1)'(window_q);
  assign elig  = (rd_entry.address != empty_q) && (limit > {1'b0, req_q.now_ms});

  always_comb begin
    wr.en             = (state_q == ST_DONE) && out_free &&
                        (req_q.func == FUNC_UPDATE) && hit_found_q;
    wr.idx            = hit_idx_q;
    wr.entry.address  = req_q.relay_address;
    wr.entry.strength = req_q.signal_strength;
    wr.entry.stamp    = req_q.now_ms;
  end

  always_comb begin
    out_d = '0;
    if (req_q.func == FUNC_UPDATE) begin
      out_d.update_dropped = !hit_found_q;
    end else begin
      out_d.best_found   = best_found_q;
      out_d.best_address = best_found_q ? best_addr_q : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!issue && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_q     <= WINDOW_RESET;
      empty_q      <= EMPTY_RESET;
      rd_cnt_q     <= '0;
      pend_q       <= 1'b0;
      hit_found_q  <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_WINDOW: window_q <= cfg_data_i[WINDOW_W-1:0];
          CFG_EMPTY:  empty_q  <= cfg_data_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      pend_q <= issue;
      if (in_fire) begin
        rd_cnt_q     <= '0;
        hit_found_q  <= 1'b0;
        best_found_q <= 1'b0;
      end else if (issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (pend_q) begin
        if (req_q.func == FUNC_UPDATE) begin
          if (hit && !hit_found_q) begin
            hit_found_q <= 1'b1;
          end
        end else if (elig && (!best_found_q || (rd_entry.strength > best_str_q))) begin
          best_found_q <= 1'b1;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    if (issue) begin
      pend_idx_q <= rd_idx;
    end
    if (pend_q) begin
      if (req_q.func == FUNC_UPDATE) begin
        if (hit && !hit_found_q) begin
          hit_idx_q <= pend_idx_q;
        end
      end else if (elig && (!best_found_q || (rd_entry.strength > best_str_q))) begin
        best_addr_q <= rd_entry.address;
        best_str_q  <= rd_entry.strength;
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_WALK) && (rd_cnt_q == '0) && !pend_q)
    else $error("accepted transaction did not start a walk");

  a_write_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ST_DONE) && (req_q.func == FUNC_UPDATE))
    else $error("table written outside an update");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.best_found && out_data_o.update_dropped))
    else $error("result flags both set");

  a_no_best_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.best_found) |-> (out_data_o.best_address == '0))
    else $error("address reported without a fresh entry");

  a_walk_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && (state_d == ST_DONE)) |-> (rd_cnt_q == CNT_W'(TABLE_ENTRIES)))
    else $error("walk ended before all entries were read");
`endif

endmodule

`default_nettype wire
